### rtl/cpftx_pkg.sv
// ----------------------------------------------------------------------------
// cpftx_pkg
// Shared types, constants and the CRC-16 byte update for the packet framer.
// ----------------------------------------------------------------------------
package cpftx_pkg;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Register indexes on the configuration channel
  localparam int          CFG_ADDR_W      = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_START_FLAG  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAYLOAD = 8'd1;

  // Register reset values
  localparam logic [7:0]  START_FLAG_RST  = 8'd126;
  localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd64;

  // Input word kinds
  localparam logic        OP_HEADER  = 1'b0;
  localparam logic        OP_PAYLOAD = 1'b1;

  // Most output words one input word can produce, and the count width
  localparam int          BURST_MAX = 5;
  localparam int          CNT_W     = $clog2(BURST_MAX + 1);

  // One output word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       rej;
  } entry_t;

  // Words produced by one input word, lowest entry goes out first
  typedef struct packed {
    logic [CNT_W-1:0]             cnt;
    entry_t [BURST_MAX-1:0]       ent;
  } burst_t;

  // Fold one byte into the CRC, MSB first
  function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/cpftx_step.sv
// ----------------------------------------------------------------------------
// cpftx_step
// Configuration registers, frame state and the per-word burst builder.
// ----------------------------------------------------------------------------
module cpftx_step
  import cpftx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]            cfg_data,
  input  logic                  in_accept,
  input  logic                  op,
  input  logic [7:0]            pkt_type,
  input  logic [7:0]            pkt_len,
  input  logic [7:0]            pld_byte,
  output burst_t                burst
);

  logic [7:0]  start_flag_r;
  logic [7:0]  max_payload_r;
  logic [15:0] crc_r,  crc_nxt;
  logic [7:0]  rem_r,  rem_nxt;
  logic        open_r, open_nxt;

  logic [15:0] hdr_crc;
  logic [15:0] pld_crc;
  logic [7:0]  rem_dec;

  // CRC candidates for both word kinds
  assign hdr_crc = crc16_add(crc16_add(CRC_INIT, pkt_type), pkt_len);
  assign pld_crc = crc16_add(crc_r, pld_byte);
  assign rem_dec = rem_r - 8'd1;

  // Burst and next state for the presented word
  always_comb begin
    burst    = '0;
    crc_nxt  = crc_r;
    rem_nxt  = rem_r;
    open_nxt = open_r;
    case (op)
      OP_HEADER: begin
        if (pkt_len > max_payload_r) begin
          burst.cnt         = CNT_W'(1);
          burst.ent[0].last = 1'b1;
          burst.ent[0].rej  = 1'b1;
        end else begin
          crc_nxt           = hdr_crc;
          burst.ent[0].data = start_flag_r;
          burst.ent[1].data = pkt_type;
          burst.ent[2].data = pkt_len;
          if (pkt_len == 8'd0) begin
            burst.cnt         = CNT_W'(5);
            burst.ent[3].data = hdr_crc[15:8];
            burst.ent[4].data = hdr_crc[7:0];
            burst.ent[4].last = 1'b1;
            rem_nxt           = 8'd0;
            open_nxt          = 1'b0;
          end else begin
            burst.cnt = CNT_W'(3);
            rem_nxt   = pkt_len;
            open_nxt  = 1'b1;
          end
        end
      end
      OP_PAYLOAD: begin
        if (open_r) begin
          crc_nxt           = pld_crc;
          burst.ent[0].data = pld_byte;
          if (rem_dec == 8'd0) begin
            burst.cnt         = CNT_W'(3);
            burst.ent[1].data = pld_crc[15:8];
            burst.ent[2].data = pld_crc[7:0];
            burst.ent[2].last = 1'b1;
            rem_nxt           = 8'd0;
            open_nxt          = 1'b0;
          end else begin
            burst.cnt = CNT_W'(1);
            rem_nxt   = rem_dec;
          end
        end
      end
      default: begin
        burst = '0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_flag_r  <= START_FLAG_RST;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_FLAG:  start_flag_r  <= cfg_data;
        REG_MAX_PAYLOAD: max_payload_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      rem_r  <= 8'd0;
      open_r <= 1'b0;
    end else if (in_accept) begin
      crc_r  <= crc_nxt;
      rem_r  <= rem_nxt;
      open_r <= open_nxt;
    end
  end

`ifndef ASSERT_OFF
  // An open packet always has payload still to come
  a_open_rem: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (rem_r != 8'd0))
    else $error("packet open with no bytes remaining");

  // A dropped payload word leaves the CRC alone
  a_drop_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && op == OP_PAYLOAD && !open_r) |=> $stable(crc_r))
    else $error("CRC changed on dropped payload word");

  // A rejected header leaves the packet state alone
  a_rej_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && op == OP_HEADER && pkt_len > max_payload_r)
      |=> ($stable(open_r) && $stable(rem_r)))
    else $error("rejected header changed packet state");
`endif

endmodule

### rtl/cpftx_serial.sv
// ----------------------------------------------------------------------------
// cpftx_serial
// Burst register sending one input word's words one per cycle unless stalled.
// ----------------------------------------------------------------------------
module cpftx_serial
  import cpftx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  burst_t     burst,
  output logic       take_ok,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic       out_tuser
);

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  entry_t [BURST_MAX-1:0] ent_r, ent_nxt;
  logic                   pop;

  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid & out_tready;
  // New burst may load once the current one is down to its last word going out
  assign take_ok    = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_tready);

  assign out_tdata = ent_r[0].data;
  assign out_tlast = ent_r[0].last;
  assign out_tuser = ent_r[0].rej;

  // Load or shift down
  always_comb begin
    cnt_nxt = cnt_r;
    ent_nxt = ent_r;
    if (load) begin
      cnt_nxt = burst.cnt;
      ent_nxt = burst.ent;
    end else if (pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      ent_nxt = {entry_t'('0), ent_r[BURST_MAX-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BURST_MAX))
    else $error("burst count out of range");

  // The frame end word is always the last of its burst
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (cnt_r == CNT_W'(1)))
    else $error("frame end word not last in burst");

  // A rejection word is always a frame end
  a_rej_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("rejection word without frame end");

  // A stalled burst is neither shifted nor replaced
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(cnt_r))
    else $error("burst count moved while stalled");
`endif

endmodule

### rtl/crc16_packet_framer_tx_core.sv
// ----------------------------------------------------------------------------
// crc16_packet_framer_tx_core
// Length-prefixed transmit framer with CRC-16/CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
// Output runs at one byte per cycle while out_tready is high; the serializer sets
// the rate. A payload word produces one output word, so a payload stream passes at
// one word per cycle; the last payload word adds the two CRC bytes. A header
// produces start flag, type and length, or 5 words with the CRC when the length is
// zero; an oversized header produces one rejection word (tuser high, data zero). A
// payload word outside a packet produces nothing. The next input word is taken in
// the cycle the previous burst's last word leaves. Configuration writes are always
// ready and take effect next cycle.
module crc16_packet_framer_tx_core
  import cpftx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]            cfg_data,
  // input words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // [7:0] packet_type, [15:8] payload_length,
                                            // [23:16] payload_byte
  input  logic                  in_tuser,   // [0] operation
  // output words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] byte_out
  output logic                  out_tlast,  // frame_end
  output logic                  out_tuser   // [0] rejected
);

  burst_t burst;
  logic   in_accept;

  assign cfg_ready = 1'b1;
  assign in_accept = in_tvalid & in_tready;

  cpftx_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .op        (in_tuser),
    .pkt_type  (in_tdata[7:0]),
    .pkt_len   (in_tdata[15:8]),
    .pld_byte  (in_tdata[23:16]),
    .burst     (burst)
  );

  cpftx_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_accept),
    .burst      (burst),
    .take_ok    (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
